[rtl/range_sum_point_update_tree_macros.svh]
// assertion macros for the range sum point update tree
`ifndef RANGE_SUM_POINT_UPDATE_TREE_MACROS_SVH
`define RANGE_SUM_POINT_UPDATE_TREE_MACROS_SVH

// checked on every rising clock edge, off while reset is high
`define RSPU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define RSPU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/rspu_pkg.sv]
// shared types and constants of the range sum point update tree
`default_nettype none

package rspu_pkg;

   localparam int LEAF_COUNT_DEFAULT = 1024;
   localparam int POS_W              = 10;
   localparam int DATA_W             = 32;
   localparam int REQ_TDATA_W        = 56;
   localparam int RSP_TDATA_W        = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WUP,
      ST_QLO,
      ST_QHI
   } seq_state_type;

   // decoded request item handed to the sequencer
   typedef struct packed {
      logic              start;
      logic              op;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  range_end;
      logic [DATA_W-1:0] value;
      logic              bad;
   } req_cmd_type;

   // sequencer status back to the top level
   typedef struct packed {
      logic              ready;
      logic              rsp_load;
      logic [DATA_W-1:0] rsp_sum;
      logic              rsp_error;
   } seq_status_type;

endpackage

`default_nettype wire

[rtl/rspu_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module rspu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/rspu_seq.sv]
// node store sequencer: clearing pass, leaf write and climb, range query walk
`default_nettype none

module rspu_seq import rspu_pkg::*; #(
   parameter int LEAF_COUNT = LEAF_COUNT_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire req_cmd_type    cmd,
   input  wire logic           out_free,
   output seq_status_type      status
);

   localparam int LEAF_W = $clog2(LEAF_COUNT);
   localparam int NODE_W = LEAF_W + 1;
   localparam int SPAN_W = NODE_W + 1;
   localparam int DEPTH  = 2 * LEAF_COUNT;

   seq_state_type state_ff, state_in;

   logic [NODE_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [SPAN_W-1:0] lo_ff, lo_in;
   logic [SPAN_W-1:0] hi_ff, hi_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;
   logic              err_ff, err_in;

   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [NODE_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic [NODE_W-1:0] leaf;
   logic [NODE_W-1:0] parent;
   logic [DATA_W-1:0] acc_sum;
   logic [SPAN_W-1:0] hi_dec;
   logic              span_open;

   rspu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign leaf      = NODE_W'(LEAF_COUNT) + NODE_W'(cmd.position);
   assign parent    = node_ff >> 1;
   assign acc_sum   = acc_ff + (pend_ff ? rd_data : '0);
   assign hi_dec    = hi_ff[0] ? (hi_ff - SPAN_W'(1)) : hi_ff;
   assign span_open = lo_ff < hi_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == OP_QUERY) state_in = ST_QLO;
               else if (!cmd.bad)      state_in = ST_WUP;
            end
         end
         ST_WUP: begin
            if (parent == NODE_W'(1)) state_in = ST_IDLE;
         end
         ST_QLO: begin
            if (span_open)     state_in = ST_QHI;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_QHI: begin
            state_in = ST_QLO;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      node_in    = node_ff;
      cur_in     = cur_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      acc_in     = acc_ff;
      pend_in    = 1'b0;
      err_in     = err_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_data    = cur_ff;
      rd_en      = 1'b0;
      rd_addr    = node_ff;
      status     = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + NODE_W'(1);
         end
         ST_IDLE: begin
            status.ready = 1'b1;
            if (cmd.start) begin
               if (cmd.op == OP_QUERY) begin
                  acc_in = '0;
                  err_in = cmd.bad;
                  if (cmd.bad) begin
                     lo_in = '0;
                     hi_in = '0;
                  end else begin
                     lo_in = SPAN_W'(LEAF_COUNT) + SPAN_W'(cmd.position);
                     hi_in = SPAN_W'(LEAF_COUNT) + SPAN_W'(cmd.range_end) + SPAN_W'(1);
                  end
               end else if (!cmd.bad) begin
                  // leaf write and first sibling read in the accept cycle
                  wr_en   = 1'b1;
                  wr_addr = leaf;
                  wr_data = cmd.value;
                  rd_en   = 1'b1;
                  rd_addr = leaf ^ NODE_W'(1);
                  node_in = leaf;
                  cur_in  = cmd.value;
               end
            end
         end
         ST_WUP: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = cur_ff + rd_data;
            rd_en   = 1'b1;
            rd_addr = parent ^ NODE_W'(1);
            node_in = parent;
            cur_in  = cur_ff + rd_data;
         end
         ST_QLO: begin
            acc_in = acc_sum;
            if (span_open) begin
               if (lo_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = NODE_W'(lo_ff);
                  lo_in   = lo_ff + SPAN_W'(1);
                  pend_in = 1'b1;
               end
            end else if (out_free) begin
               status.rsp_load  = 1'b1;
               status.rsp_sum   = err_ff ? '0 : acc_sum;
               status.rsp_error = err_ff;
            end
         end
         ST_QHI: begin
            acc_in = acc_sum;
            if (hi_ff[0]) begin
               rd_en   = 1'b1;
               rd_addr = NODE_W'(hi_dec);
               pend_in = 1'b1;
            end
            lo_in = lo_ff >> 1;
            hi_in = hi_dec >> 1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      cur_ff  <= cur_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      acc_ff  <= acc_in;
      err_ff  <= err_in;
   end

endmodule

`default_nettype wire

[rtl/range_sum_point_update_tree.sv]
// top level of the range sum point update tree: request decode, result register
`default_nettype none

`include "range_sum_point_update_tree_macros.svh"

// Binary sum tree over LEAF_COUNT signed 32-bit elements (LEAF_COUNT a power
// of two, 2 to 1024), held in one 2*LEAF_COUNT entry ram with one write and
// one registered read port. After reset a clearing pass zeroes all 2*LEAF_COUNT
// entries of the ram, one entry a cycle, while req_tready stays low. A write
// item (tuser 0) stores the element and then climbs to the root with one
// read-modify-write per level, and it gives no result. A query item (tuser 1)
// walks both range ends up the tree level by level, the lower end in ST_QLO and
// the upper end in ST_QHI, after the accept cycle and before a closing step in
// ST_QLO; its result leaves through an output register, so the next item is
// taken while a result waits. A reversed or out of bounds query returns sum
// zero with rsp_tuser high. A write to a position at or beyond LEAF_COUNT is
// dropped. Sums wrap in 32 bits.
module range_sum_point_update_tree import rspu_pkg::*; #(
   parameter int LEAF_COUNT = LEAF_COUNT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [9:0] position, [19:10] range_end, [51:20] value, [55:52] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] operation
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] range_sum
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] range_error
   output logic                        rsp_tuser
);

   req_cmd_type    cmd;
   seq_status_type status;

   logic              req_accept;
   logic              work_accept;
   logic              out_free;
   logic              pos_oob;
   logic              end_oob;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff;
   logic              rsp_error_ff;

   assign req_tready = status.ready;
   assign req_accept = req_tvalid && req_tready;

   // field unpacking and range checks
   assign pos_oob = 32'(req_tdata[POS_W-1:0]) >= 32'(LEAF_COUNT);
   assign end_oob = 32'(req_tdata[2*POS_W-1:POS_W]) >= 32'(LEAF_COUNT);

   always_comb begin
      cmd.start     = req_accept;
      cmd.op        = req_tuser;
      cmd.position  = req_tdata[POS_W-1:0];
      cmd.range_end = req_tdata[2*POS_W-1:POS_W];
      cmd.value     = req_tdata[2*POS_W+DATA_W-1:2*POS_W];
      // query: reversed or out of range; write: position out of range
      if (req_tuser == OP_QUERY) begin
         cmd.bad = (cmd.position > cmd.range_end) || pos_oob || end_oob;
      end else begin
         cmd.bad = pos_oob;
      end
   end

   // accepted item that starts a walk or a climb
   assign work_accept = req_accept && !(cmd.op == OP_WRITE && cmd.bad);

   // result slot is free when empty or being emptied this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   rspu_seq #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .out_free (out_free),
      .status   (status)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.rsp_load)  rsp_valid_in = 1'b1;
      else if (rsp_tready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.rsp_load) begin
         rsp_sum_ff   <= status.rsp_sum;
         rsp_error_ff <= status.rsp_error;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_sum_ff);
   assign rsp_tuser  = rsp_error_ff;

   // a result is only loaded into a free slot
   `RSPU_ASSERT(a_load_into_free, status.rsp_load |-> out_free, "result over a waiting item")
   // any item that does work keeps the block busy in the next cycle
   `RSPU_ASSERT(a_busy_after_accept, work_accept |=> !req_tready, "item accepted while busy")
   // clearing pass follows reset
   `RSPU_ASSERT_ALWAYS(a_clear_after_reset, reset |=> !req_tready, "item taken in clearing")
   // an error result always carries a zero sum
   `RSPU_ASSERT(a_error_zero_sum, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "nonzero error sum")

endmodule

`default_nettype wire

[sim/rspu_result_checker.sv]
// watches both streams of the sum tree, keeps its own element array and checks each result item
module rspu_result_checker import rspu_pkg::*; #(
   parameter int LEAF_COUNT = LEAF_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   output int                     mismatch_count,
   output int                     pending_count
);

   typedef struct {
      logic [DATA_W-1:0] sum;
      logic              error;
   } range_result_type;

   // flat copy of the leaves, the tree shape cannot change a wrapped sum
   logic [DATA_W-1:0] elements [LEAF_COUNT];
   range_result_type  expected_results [$];
   int                mismatches;

   function automatic logic [DATA_W-1:0] element_sum(int first, int last);
      logic [DATA_W-1:0] acc = '0;
      for (int i = first; i <= last; i++) acc += elements[i];
      return acc;
   endfunction

   always @(posedge clock) begin : watch
      range_result_type  want;
      range_result_type  got;
      logic [POS_W-1:0]  first;
      logic [POS_W-1:0]  last;
      if (reset) begin
         foreach (elements[i]) elements[i] = '0;
         expected_results.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item: range_sum %0d range_error %0b",
                      $signed(rsp_tdata), rsp_tuser);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.sum) begin
                  $error("range_sum: expected %0d, actual %0d",
                         $signed(want.sum), $signed(rsp_tdata));
                  mismatches++;
               end
               if (rsp_tuser !== want.error) begin
                  $error("range_error: expected %0b, actual %0b", want.error, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            first = req_tdata[POS_W-1:0];
            last  = req_tdata[2*POS_W-1:POS_W];
            if (req_tuser == OP_WRITE) begin
               // writes past the last leaf are dropped without a result
               if (first < LEAF_COUNT) elements[first] = req_tdata[2*POS_W +: DATA_W];
            end else begin
               if (first > last || first >= LEAF_COUNT || last >= LEAF_COUNT) begin
                  got.sum   = '0;
                  got.error = 1'b1;
               end else begin
                  got.sum   = element_sum(first, last);
                  got.error = 1'b0;
               end
               expected_results.push_back(got);
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_results.size();
   end

endmodule

[sim/tb_top.sv]
// stimulus, clock, reset and verdict for the range sum point update tree
module tb_top;
   import rspu_pkg::*;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [9:0] position, [19:10] range_end, [51:20] value, [55:52] zero
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // [0] operation
   logic                   req_tuser  = OP_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [31:0] range_sum
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [0] range_error
   logic                   rsp_tuser;

   int mismatch_count;
   int pending_count;

   // stimulus bookkeeping for the closing summary
   int writes_sent;
   int queries_sent;
   int reversed_sent;

   // burst flags switch off the random gaps for whole stretches
   bit req_burst;
   bit rsp_burst;

   localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] INT_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;
   localparam int LAST_LEAF = LEAF_COUNT_DEFAULT - 1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   range_sum_point_update_tree #(.LEAF_COUNT(LEAF_COUNT_DEFAULT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rspu_result_checker #(.LEAF_COUNT(LEAF_COUNT_DEFAULT)) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // offer one item after a random gap and hold it until the tree takes it;
   // with no gap tvalid simply stays high for the next item
   task automatic send_item(input logic op, input logic [POS_W-1:0] first,
                            input logic [POS_W-1:0] last, input logic [DATA_W-1:0] val);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-2*POS_W-DATA_W){1'b0}}, val, last, first};
      do @(posedge clock); while (!req_tready);
      if (op == OP_WRITE) writes_sent++;
      else begin
         queries_sent++;
         if (first > last) reversed_sent++;
      end
   endtask

   // element values lean toward the extremes so the sums wrap often
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return INT_MIN;
         1:       return INT_MAX;
         2:       return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   // result side: a random stall before each result item, bursts of none
   initial begin
      int stall;
      int served;
      served = 0;
      @(posedge clock);
      forever begin
         if (served % 32 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         stall = rsp_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         served++;
      end
   end

   initial begin
      logic [POS_W-1:0] first;
      logic [POS_W-1:0] last;
      int               pick;
      writes_sent   = 0;
      queries_sent  = 0;
      reversed_sent = 0;
      req_burst     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part: the request side waits out the clearing pass here
      send_item(OP_QUERY, 0, LAST_LEAF, 0);            // cleared tree sums to zero
      send_item(OP_WRITE, 0, 0, INT_MIN);
      send_item(OP_WRITE, LAST_LEAF, LAST_LEAF, INT_MAX);
      send_item(OP_WRITE, 512, 0, ALL_ONES);
      send_item(OP_WRITE, 1, LAST_LEAF, 1);
      send_item(OP_QUERY, 0, LAST_LEAF, 0);
      send_item(OP_QUERY, 0, 0, ALL_ONES);             // value field ignored on queries
      send_item(OP_QUERY, LAST_LEAF, LAST_LEAF, 0);
      send_item(OP_QUERY, 0, 1, 0);
      send_item(OP_QUERY, LAST_LEAF - 1, LAST_LEAF, 0);
      send_item(OP_QUERY, LAST_LEAF, 0, INT_MAX);      // reversed range
      send_item(OP_QUERY, 513, 512, 0);                // reversed by one
      send_item(OP_WRITE, LAST_LEAF, 0, INT_MIN);      // full sum now wraps
      send_item(OP_QUERY, 0, LAST_LEAF, 0);
      send_item(OP_QUERY, 511, 513, 0);
      send_item(OP_WRITE, 700, LAST_LEAF, ALL_ONES);   // range_end ignored on writes
      send_item(OP_QUERY, 700, 700, ALL_ONES);
      send_item(OP_WRITE, 0, 0, 0);                    // overwrite back to zero
      send_item(OP_QUERY, 0, 0, 0);
      send_item(OP_QUERY, 0, 700, 0);

      // random part: mostly well-formed queries and writes, some reversed ranges
      for (int n = 0; n < 1030; n++) begin
         if (n % 40 == 0) req_burst = ($urandom_range(0, 3) == 0);
         pick  = $urandom_range(0, 99);
         first = $urandom_range(0, LAST_LEAF);
         last  = $urandom_range(0, LAST_LEAF);
         if (pick < 45) begin
            send_item(OP_WRITE, first, last, pick_value());
         end else if (pick < 55) begin
            first = $urandom_range(1, LAST_LEAF);
            last  = $urandom_range(0, first - 1);
            send_item(OP_QUERY, first, last, $urandom);
         end else if (pick < 78) begin
            // short range around a random point
            last = (first + $urandom_range(0, 15) > LAST_LEAF) ? LAST_LEAF[POS_W-1:0]
                                                               : first + $urandom_range(0, 15);
            send_item(OP_QUERY, first, last, $urandom);
         end else begin
            if (first > last) send_item(OP_QUERY, last, first, $urandom);
            else send_item(OP_QUERY, first, last, $urandom);
         end
      end
      req_tvalid <= 1'b0;

      // drain: every query answered, then quiet cycles before the verdict
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);

      $display("summary: %0d writes and %0d queries sent, %0d of them reversed ranges",
               writes_sent, queries_sent, reversed_sent);
      $display("summary: %0d field mismatches seen", mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // guard against a hung handshake; far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/rspu_pkg.sv
rtl/rspu_ram.sv
rtl/rspu_seq.sv
rtl/range_sum_point_update_tree.sv
sim/rspu_result_checker.sv
sim/tb_top.sv
